FILE: sv/adkf_pkg.sv
`timescale 1ns / 1ps
package adkf_pkg;

  localparam int GEN_CAPACITY = 16384;
  localparam int IDX_W        = $clog2(GEN_CAPACITY);
  localparam int CNT_W        = IDX_W + 1;
  localparam int ADDR_W       = IDX_W + 1;
  localparam int STORE_DEPTH  = 2 * GEN_CAPACITY;
  localparam int KEY_W        = 64;
  localparam int THR_W        = 14;
  localparam int TYPE_W       = 16;
  localparam int FUNC_W       = 2;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  localparam logic [THR_W-1:0]  THR_RESET    = 14'd10000;
  localparam logic [TYPE_W-1:0] TYPE_A_RESET = 16'd256;
  localparam logic [TYPE_W-1:0] TYPE_B_RESET = 16'd257;
  localparam logic [TYPE_W-1:0] TYPE_C_RESET = 16'd258;

  localparam logic [FUNC_W-1:0] FUNC_ADD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_AGE = 2'd2;

  localparam logic [1:0] REG_THR    = 2'd0;
  localparam logic [1:0] REG_TYPE_A = 2'd1;
  localparam logic [1:0] REG_TYPE_B = 2'd2;
  localparam logic [1:0] REG_TYPE_C = 2'd3;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_ADD,
    OP_DEL,
    OP_AGE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             ignored;
    logic [KEY_W-1:0] key;
  } item_t;

endpackage

FILE: sv/adkf_ram.sv
`timescale 1ns / 1ps
module adkf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/adkf_front.sv
`timescale 1ns / 1ps
module adkf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [adkf_pkg::PADDR_W-1:0] paddr,
  input  logic [adkf_pkg::PDATA_W-1:0] pwdata,
  output logic [adkf_pkg::PDATA_W-1:0] prdata,
  input  logic [adkf_pkg::FUNC_W-1:0]  func,
  input  logic [adkf_pkg::TYPE_W-1:0]  msg_type,
  input  logic [adkf_pkg::KEY_W-1:0]   key,
  output adkf_pkg::item_t              item,
  output logic [adkf_pkg::THR_W-1:0]   thr
);
  import adkf_pkg::*;

  logic [THR_W-1:0]  thr_r;
  logic [TYPE_W-1:0] type_a_r, type_b_r, type_c_r;
  logic              wr_en;
  logic              tracked;

  assign wr_en = psel && penable && pwrite;
  assign thr   = thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_RESET;
      type_a_r <= TYPE_A_RESET;
      type_b_r <= TYPE_B_RESET;
      type_c_r <= TYPE_C_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_THR:    thr_r    <= pwdata[THR_W-1:0];
        REG_TYPE_A: type_a_r <= pwdata[TYPE_W-1:0];
        REG_TYPE_B: type_b_r <= pwdata[TYPE_W-1:0];
        REG_TYPE_C: type_c_r <= pwdata[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_THR:    prdata = {{(PDATA_W-THR_W){1'b0}}, thr_r};
      REG_TYPE_A: prdata = {{(PDATA_W-TYPE_W){1'b0}}, type_a_r};
      REG_TYPE_B: prdata = {{(PDATA_W-TYPE_W){1'b0}}, type_b_r};
      REG_TYPE_C: prdata = {{(PDATA_W-TYPE_W){1'b0}}, type_c_r};
      default:    prdata = '0;
    endcase
  end

  // classify: untracked add/delete becomes a no-op flagged as ignored
  assign tracked = (msg_type == type_a_r) || (msg_type == type_b_r) ||
                   (msg_type == type_c_r);

  always_comb begin
    item.key     = key;
    item.ignored = 1'b0;
    case (func) inside
      FUNC_ADD, FUNC_DEL: begin
        item.ignored = !tracked;
        if (!tracked) begin
          item.op = OP_NOP;
        end else if (func == FUNC_ADD) begin
          item.op = OP_ADD;
        end else begin
          item.op = OP_DEL;
        end
      end
      FUNC_AGE: item.op = OP_AGE;
      default:  item.op = OP_NOP;
    endcase
  end

endmodule

FILE: sv/adkf_fifo.sv
`timescale 1ns / 1ps
module adkf_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  adkf_pkg::item_t push_item,
  input  logic            pop,
  output adkf_pkg::item_t head,
  output logic            empty,
  output logic            full
);
  import adkf_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: sv/adkf_back.sv
`timescale 1ns / 1ps
module adkf_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       empty,
  input  adkf_pkg::item_t            head,
  output logic                       pop,
  input  logic [adkf_pkg::THR_W-1:0] thr,
  output logic                       res_valid,
  output logic                       res_found,
  output logic                       res_ignored,
  output logic                       res_aged,
  output logic [adkf_pkg::CNT_W-1:0] res_count
);
  import adkf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RM_RD, S_RM_WR} state_t;

  state_t             state_r, state_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic               cur_r, cur_nxt;
  logic               bank_r, bank_nxt;
  logic [CNT_W-1:0]   cnt_r [2];
  logic [CNT_W-1:0]   cnt_nxt [2];
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pidx_r, pidx_nxt;
  logic [IDX_W-1:0]   hole_r, hole_nxt;
  logic               valid_r, valid_nxt;
  logic               found_r, found_nxt;
  logic               ign_r, ign_nxt;
  logic               aged_r, aged_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic               we;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [KEY_W-1:0]   wdata, rdata;
  logic [CNT_W-1:0]   add_cnt, last_cnt;
  logic               hit;

  adkf_ram #(.WIDTH(KEY_W), .DEPTH(STORE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign add_cnt  = cnt_r[cur_r] + CNT_W'(1);
  assign last_cnt = cnt_r[bank_r] - CNT_W'(1);
  assign hit      = pend_r && (rdata == key_r);

  always_comb begin
    state_nxt  = state_r;
    key_nxt    = key_r;
    cur_nxt    = cur_r;
    bank_nxt   = bank_r;
    cnt_nxt[0] = cnt_r[0];
    cnt_nxt[1] = cnt_r[1];
    idx_nxt    = idx_r;
    pend_nxt   = pend_r;
    pidx_nxt   = pidx_r;
    hole_nxt   = hole_r;
    valid_nxt  = 1'b0;
    found_nxt  = 1'b0;
    ign_nxt    = 1'b0;
    aged_nxt   = 1'b0;
    count_nxt  = count_r;
    pop        = 1'b0;
    we         = 1'b0;
    waddr      = {cur_r, cnt_r[cur_r][IDX_W-1:0]};
    wdata      = head.key;
    raddr      = {bank_r, idx_r[IDX_W-1:0]};

    case (state_r)
      S_IDLE: begin
        if (!empty) begin
          pop       = 1'b1;
          valid_nxt = 1'b1;
          count_nxt = cnt_r[cur_r];
          case (head.op)
            OP_ADD: begin
              // append to the current bank; age when over threshold or full
              we = 1'b1;
              if (add_cnt > {1'b0, thr} || add_cnt >= CNT_W'(GEN_CAPACITY)) begin
                cnt_nxt[cur_r]  = add_cnt;
                cnt_nxt[!cur_r] = '0;
                cur_nxt         = !cur_r;
                aged_nxt        = 1'b1;
                count_nxt       = '0;
              end else begin
                cnt_nxt[cur_r] = add_cnt;
                count_nxt      = add_cnt;
              end
            end
            OP_AGE: begin
              cnt_nxt[!cur_r] = '0;
              cur_nxt         = !cur_r;
              aged_nxt        = 1'b1;
              count_nxt       = '0;
            end
            OP_DEL: begin
              valid_nxt = 1'b0;
              key_nxt   = head.key;
              bank_nxt  = cur_r;
              idx_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_SCAN;
            end
            default: ign_nxt = head.ignored;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          hole_nxt  = pidx_r;
          pend_nxt  = 1'b0;
          state_nxt = S_RM_RD;
        end else if (idx_r < cnt_r[bank_r]) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (bank_r == cur_r) begin
            bank_nxt = !cur_r;
            idx_nxt  = '0;
          end else begin
            valid_nxt = 1'b1;
            count_nxt = cnt_r[cur_r];
            state_nxt = S_IDLE;
          end
        end
      end
      S_RM_RD: begin
        raddr     = {bank_r, last_cnt[IDX_W-1:0]};
        state_nxt = S_RM_WR;
      end
      S_RM_WR: begin
        // move the last entry of the bank into the hole
        we              = 1'b1;
        waddr           = {bank_r, hole_r};
        wdata           = rdata;
        cnt_nxt[bank_r] = last_cnt;
        valid_nxt       = 1'b1;
        found_nxt       = 1'b1;
        count_nxt       = (bank_r == cur_r) ? last_cnt : cnt_r[cur_r];
        state_nxt       = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    pidx_r  <= pidx_nxt;
    hole_r  <= hole_nxt;
    found_r <= found_nxt;
    ign_r   <= ign_nxt;
    aged_r  <= aged_nxt;
    count_r <= count_nxt;
    idx_r   <= idx_nxt;
    bank_r  <= bank_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cur_r    <= 1'b0;
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      pend_r   <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      cnt_r[0] <= cnt_nxt[0];
      cnt_r[1] <= cnt_nxt[1];
      pend_r   <= pend_nxt;
      valid_r  <= valid_nxt;
    end
  end

  assign res_valid   = valid_r;
  assign res_found   = found_r;
  assign res_ignored = ign_r;
  assign res_aged    = aged_r;
  assign res_count   = count_r;

endmodule

FILE: sv/aging_duplicate_key_filter_unit.sv
`timescale 1ns / 1ps
// Aging duplicate-key filter: remembers 64-bit message keys in a current and
// an old generation, each a multiset held as a packed list in one bank of a
// key RAM, with a fill count per bank.
// Input: a command beat is taken when start is high and busy is low. busy
// rises while the two-entry command queue is full.
// Output: exactly one result beat per command, on out_valid for one cycle;
// the receiver cannot stall, so results are never held back.
// Flow: add, age, ignored and unused commands pass through the command queue
// and the result registers, and the back end never stalls on them. A delete
// scans the current bank and then the old bank one key per cycle, stalling
// the queue until the key is found or both banks are exhausted.
// Removing a key moves the last key of its bank into the hole (read, then write).
// Aging flips the bank roles and zeroes the fill count of the new current
// bank, so no RAM sweep is needed and reset needs no clearing pass.
// Reset: synchronous, active low; both banks empty, registers at defaults
// (threshold 10000, tracked types 256, 257, 258). Write registers through
// the APB port only while no command is outstanding.
module aging_duplicate_key_filter_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [adkf_pkg::PADDR_W-1:0] paddr,
  input  logic [adkf_pkg::PDATA_W-1:0] pwdata,
  output logic [adkf_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic [adkf_pkg::FUNC_W-1:0]  in_func,
  input  logic [adkf_pkg::TYPE_W-1:0]  in_msg_type,
  input  logic [adkf_pkg::KEY_W-1:0]   in_key,
  output logic                         out_valid,
  output logic                         out_found,
  output logic                         out_ignored,
  output logic                         out_aged,
  output logic [adkf_pkg::CNT_W-1:0]   out_current_count
);
  import adkf_pkg::*;

  item_t            fr_item, q_head;
  logic [THR_W-1:0] thr;
  logic             push, pop, q_empty, q_full;

  assign pready = 1'b1;
  assign busy   = q_full;
  // accept a beat whenever the queue has room
  assign push   = start && !q_full;

  adkf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .func     (in_func),
    .msg_type (in_msg_type),
    .key      (in_key),
    .item     (fr_item),
    .thr      (thr)
  );

  adkf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (fr_item),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  adkf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (q_empty),
    .head        (q_head),
    .pop         (pop),
    .thr         (thr),
    .res_valid   (out_valid),
    .res_found   (out_found),
    .res_ignored (out_ignored),
    .res_aged    (out_aged),
    .res_count   (out_current_count)
  );

  // the current generation never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_current_count <= CNT_W'(GEN_CAPACITY))
    else $error("current count above capacity");

  // aging always leaves the current generation empty
  a_aged_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_aged |-> out_current_count == '0)
    else $error("aged result with nonzero count");

  // a found delete is never ignored and never ages
  a_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> !out_ignored && !out_aged)
    else $error("found combined with ignored or aged");

  // the back end never pops a queue left empty with no beat pushed into it
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty && !start |=> !pop)
    else $error("pop from empty queue");

endmodule
